// ===== design/shb_pkg.sv =====
// shared types, constants and saturating helpers for the send burst histogram
// no dependencies
package shb_pkg;

  localparam int NUM_BINS_DEF = 64;
  localparam int SIZE_W       = 7;
  localparam int TICK_W       = 64;
  localparam int LEN_W        = 16;
  localparam int CNT16_W      = 16;
  localparam int CNT32_W      = 32;

  // one histogram bin as stored in the bin memory
  typedef struct packed {
    logic [CNT32_W-1:0] count;
    logic [CNT32_W-1:0] rtx;
    logic [CNT32_W-1:0] prb;
  } bin_t;

  // burst that closes on the item being accepted
  typedef struct packed {
    logic               fire;
    logic [CNT16_W-1:0] rtx;
    logic [CNT16_W-1:0] prb;
  } close_t;

  function automatic logic [CNT32_W-1:0] sat_add32(input logic [CNT32_W-1:0] a,
                                                   input logic [CNT32_W-1:0] b);
    logic [CNT32_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT32_W] ? {CNT32_W{1'b1}} : s[CNT32_W-1:0];
  endfunction

  function automatic logic [CNT16_W-1:0] sat_inc16(input logic [CNT16_W-1:0] a);
    return (&a) ? a : a + CNT16_W'(1);
  endfunction

endpackage

// ===== design/shb_burst.sv =====
// open burst accumulator, current tick and peak tracking
// depends on shb_pkg
module shb_burst #(
  parameter int NUM_BINS = shb_pkg::NUM_BINS_DEF,
  parameter int BIN_W    = $clog2(NUM_BINS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          kind,
  input  logic [shb_pkg::TICK_W-1:0]    loop_time,
  input  logic [shb_pkg::LEN_W-1:0]     packet_length,
  input  logic                          is_retransmission,
  input  logic                          is_probation,
  input  logic                          clear_peaks,
  output shb_pkg::close_t               close,
  output logic [BIN_W-1:0]              close_idx,
  output logic [shb_pkg::CNT16_W-1:0]   peak_packets,
  output logic [shb_pkg::CNT32_W-1:0]   peak_bytes
);
  import shb_pkg::*;

  logic [TICK_W-1:0]  current_tick;
  logic [CNT16_W-1:0] open_packets;
  logic [CNT32_W-1:0] open_bytes;
  logic [CNT16_W-1:0] open_rtx;
  logic [CNT16_W-1:0] open_prb;
  logic               new_tick;
  logic               closing;
  logic [CNT16_W-1:0] base_packets;
  logic [CNT32_W-1:0] base_bytes;
  logic [CNT16_W-1:0] base_rtx;
  logic [CNT16_W-1:0] base_prb;

  assign new_tick = (loop_time != current_tick);
  assign closing  = accept && (kind || new_tick) && (open_packets != '0);

  assign close.fire = closing;
  assign close.rtx  = open_rtx;
  assign close.prb  = open_prb;

  // bursts of NUM_BINS packets or more land in the top bin
  assign close_idx = (open_packets >= CNT16_W'(NUM_BINS)) ? BIN_W'(NUM_BINS - 1)
                                                          : BIN_W'(open_packets - CNT16_W'(1));

  // a new tick starts the burst from empty
  assign base_packets = new_tick ? '0 : open_packets;
  assign base_bytes   = new_tick ? '0 : open_bytes;
  assign base_rtx     = new_tick ? '0 : open_rtx;
  assign base_prb     = new_tick ? '0 : open_prb;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_tick <= '0;
      open_packets <= '0;
      open_bytes   <= '0;
      open_rtx     <= '0;
      open_prb     <= '0;
      peak_packets <= '0;
      peak_bytes   <= '0;
    end else begin
      if (accept && !kind) begin
        current_tick <= loop_time;
        open_packets <= sat_inc16(base_packets);
        open_bytes   <= sat_add32(base_bytes, CNT32_W'(packet_length));
        open_rtx     <= is_retransmission ? sat_inc16(base_rtx) : base_rtx;
        open_prb     <= is_probation ? sat_inc16(base_prb) : base_prb;
      end else if (accept && kind) begin
        open_packets <= '0;
        open_bytes   <= '0;
        open_rtx     <= '0;
        open_prb     <= '0;
      end
      if (clear_peaks) begin
        peak_packets <= '0;
        peak_bytes   <= '0;
      end else if (closing) begin
        if (open_packets > peak_packets) peak_packets <= open_packets;
        if (open_bytes > peak_bytes) peak_bytes <= open_bytes;
      end
    end
  end

endmodule

// ===== design/shb_bin_mem.sv =====
// histogram bin memory, one read and one write port, registered read
// per-entry valid bits make unwritten or cleared bins read as zero
// depends on shb_pkg
module shb_bin_mem #(
  parameter int NUM_BINS = shb_pkg::NUM_BINS_DEF,
  parameter int BIN_W    = $clog2(NUM_BINS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear_all,
  input  logic                wr_en,
  input  logic [BIN_W-1:0]    wr_addr,
  input  shb_pkg::bin_t       wr_data,
  input  logic [BIN_W-1:0]    rd_addr,
  output shb_pkg::bin_t       rd_data,
  output logic [NUM_BINS-1:0] valid_mask
);
  import shb_pkg::*;

  bin_t mem [NUM_BINS];
  bin_t rd_q;
  logic rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_mask <= '0;
      rd_ok      <= 1'b0;
    end else begin
      rd_ok <= valid_mask[rd_addr];
      if (clear_all) begin
        valid_mask <= '0;
      end else if (wr_en) begin
        valid_mask[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

// ===== design/send_burst_histogram_top.sv =====
// send burst histogram: bursts of same-tick packets binned by packet count
// packet item: taken in idle; one that closes a burst reads its bin, then writes it back
// dump item: taken in idle, closes any open burst, then scans the bins in order up to the
// highest nonzero bin and loads one result per nonzero bin, holding while out_stall is high
// reset: synchronous, clears burst state, peaks and all bin valid bits at once
// (no clearing pass); depends on shb_pkg, shb_burst, shb_bin_mem
module send_burst_histogram_top #(
  parameter int NUM_BINS = shb_pkg::NUM_BINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input item channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [shb_pkg::TICK_W-1:0]    loop_time,
  input  logic [shb_pkg::LEN_W-1:0]     packet_length,
  input  logic                          is_retransmission,
  input  logic                          is_probation,
  // result item channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [shb_pkg::SIZE_W-1:0]    burst_size,
  output logic [shb_pkg::CNT32_W-1:0]   burst_count,
  output logic [shb_pkg::CNT32_W-1:0]   retransmission_total,
  output logic [shb_pkg::CNT32_W-1:0]   probation_total,
  output logic [shb_pkg::CNT16_W-1:0]   max_burst_packets,
  output logic [shb_pkg::CNT32_W-1:0]   max_burst_bytes,
  output logic                          last
);
  import shb_pkg::*;

  localparam int BIN_W = $clog2(NUM_BINS);

  typedef enum logic [1:0] {
    S_IDLE,   // take items
    S_CLOSE,  // bin data back from memory, write the updated bin
    S_SCAN,   // step through bins looking for valid ones
    S_LOAD    // bin data back, move it into the output register
  } state_t;

  state_t              state;
  logic                dump_pending;
  logic [BIN_W-1:0]    hold_idx;
  logic [CNT16_W-1:0]  hold_rtx;
  logic [CNT16_W-1:0]  hold_prb;
  logic [BIN_W-1:0]    scan_idx;

  logic                accept;
  logic                out_take;
  close_t              close;
  logic [BIN_W-1:0]    close_idx;
  logic [CNT16_W-1:0]  peak_packets;
  logic [CNT32_W-1:0]  peak_bytes;

  logic                mem_wr_en;
  bin_t                mem_wr_data;
  logic [BIN_W-1:0]    mem_rd_addr;
  bin_t                mem_rd_data;
  logic [NUM_BINS-1:0] valid_mask;

  logic [NUM_BINS-1:0] upper_mask;
  logic                any_left;
  logic                any_later;
  logic                load;
  logic                finish;

  // items are only taken between operations; a result left in the output
  // register does not block
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  shb_burst #(
    .NUM_BINS (NUM_BINS),
    .BIN_W    (BIN_W)
  ) u_burst (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .kind              (kind),
    .loop_time         (loop_time),
    .packet_length     (packet_length),
    .is_retransmission (is_retransmission),
    .is_probation      (is_probation),
    .clear_peaks       (finish),
    .close             (close),
    .close_idx         (close_idx),
    .peak_packets      (peak_packets),
    .peak_bytes        (peak_bytes)
  );

  // read address: closing bin on accept, held bin while closing, else scan
  always_comb begin
    case (state)
      S_IDLE:  mem_rd_addr = close_idx;
      S_CLOSE: mem_rd_addr = hold_idx;
      default: mem_rd_addr = scan_idx;
    endcase
  end

  // read-modify-write of the closing bin; read was issued on accept
  assign mem_wr_en         = (state == S_CLOSE);
  assign mem_wr_data.count = sat_add32(mem_rd_data.count, CNT32_W'(1));
  assign mem_wr_data.rtx   = sat_add32(mem_rd_data.rtx, CNT32_W'(hold_rtx));
  assign mem_wr_data.prb   = sat_add32(mem_rd_data.prb, CNT32_W'(hold_prb));

  shb_bin_mem #(
    .NUM_BINS (NUM_BINS),
    .BIN_W    (BIN_W)
  ) u_mem (
    .clk        (clk),
    .rst        (rst),
    .clear_all  (finish),
    .wr_en      (mem_wr_en),
    .wr_addr    (hold_idx),
    .wr_data    (mem_wr_data),
    .rd_addr    (mem_rd_addr),
    .rd_data    (mem_rd_data),
    .valid_mask (valid_mask)
  );

  // a valid bin always has a nonzero count, so valid bits drive the walk
  assign upper_mask = {NUM_BINS{1'b1}} << scan_idx;
  assign any_left   = |(valid_mask & upper_mask);
  assign any_later  = |(valid_mask & (upper_mask << 1));

  // output register free or emptying this cycle
  assign load   = (state == S_LOAD) && (!out_valid || out_take);
  // end of dump: clear bins and peaks (empty dump clears nothing that is set)
  assign finish = ((state == S_SCAN) && !any_left) || (load && !any_later);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      dump_pending <= 1'b0;
      scan_idx     <= '0;
      out_valid    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            dump_pending <= kind;
            scan_idx     <= '0;
            if (close.fire) begin
              state <= S_CLOSE;
            end else if (kind) begin
              state <= S_SCAN;
            end
          end
        end
        S_CLOSE: begin
          state <= dump_pending ? S_SCAN : S_IDLE;
        end
        S_SCAN: begin
          if (!any_left) begin
            state <= S_IDLE;
          end else if (valid_mask[scan_idx]) begin
            state <= S_LOAD;
          end else begin
            scan_idx <= scan_idx + BIN_W'(1);
          end
        end
        S_LOAD: begin
          if (load) begin
            if (any_later) begin
              scan_idx <= scan_idx + BIN_W'(1);
              state    <= S_SCAN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // burst capture for the write-back cycle
  always_ff @(posedge clk) begin
    if (accept && close.fire) begin
      hold_idx <= close_idx;
      hold_rtx <= close.rtx;
      hold_prb <= close.prb;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      burst_size           <= SIZE_W'(scan_idx) + SIZE_W'(1);
      burst_count          <= mem_rd_data.count;
      retransmission_total <= mem_rd_data.rtx;
      probation_total      <= mem_rd_data.prb;
      max_burst_packets    <= peak_packets;
      max_burst_bytes      <= peak_bytes;
      last                 <= !any_later;
    end
  end

endmodule
